[design/tile_grid_edge_extract_core_macros.svh]
// assertion macros for the port level checks of the edge extract core
`ifndef TILE_GRID_EDGE_EXTRACT_CORE_MACROS_SVH
`define TILE_GRID_EDGE_EXTRACT_CORE_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define TGEE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("edge extract check failed");

// consequent must hold in the same cycle as the antecedent
`define TGEE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("edge extract check failed");

`endif

[design/tgee_pkg.sv]
// shared types, constants and functions of the tile grid edge extractor
`default_nettype none
package tgee_pkg;

    localparam int MAX_ROWS    = 32;
    localparam int MAX_EDGES   = 65536;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int ID_W        = $clog2(MAX_EDGES);
    localparam int CNT_W       = $clog2(MAX_EDGES + 1);
    localparam int COL_W       = 11;
    localparam int HGT_W       = 6;
    localparam int BS_W        = 8;
    localparam int ORG_W       = 10;
    localparam int COORD_W     = 19;
    localparam int NUM_REGS    = 5;
    localparam int ADDR_W      = $clog2(NUM_REGS * 4);
    localparam int IDX_W       = ADDR_W - 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int LANES       = 4;
    localparam int LANE_W      = $clog2(LANES);

    localparam logic [IDX_W-1:0] REG_WIDTH  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_HEIGHT = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_BSIZE  = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_OCOL   = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_OROW   = IDX_W'(4);

    typedef struct packed {
        logic [COL_W-1:0] width;
        logic [HGT_W-1:0] height;
        logic [BS_W-1:0]  bsize;
        logic [ORG_W-1:0] ocol;
        logic [ORG_W-1:0] orow;
    } cfg_t;

    // one interior cell, classified by the front part
    typedef struct packed {
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
        logic             has_w;
        logic             has_e;
        logic             has_n;
        logic             has_s;
        logic             fv;
        logic             fh;
        logic             frame_end;
    } job_t;

    // a finished edge before its coordinates are scaled
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic             vert;
        logic [COL_W-1:0] fixed;
        logic [COL_W-1:0] start;
        logic [COL_W-1:0] stop;
    } fin_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic {
        B_IDLE,
        B_EMIT
    } back_state_t;

    function automatic logic [COORD_W-1:0] coord(input logic [ORG_W-1:0] org,
                                                 input logic [COL_W-1:0] idx,
                                                 input logic [BS_W-1:0]  bs);
        logic [COL_W:0]           sum;
        logic [COL_W+BS_W:0]      prod;
        sum  = (COL_W+1)'(org) + (COL_W+1)'(idx);
        prod = (COL_W+BS_W+1)'(sum) * (COL_W+BS_W+1)'(bs);
        return prod[COORD_W-1:0];
    endfunction

endpackage
`default_nettype wire

[design/tgee_front.sv]
// front part: column bit stores, scan counters and cell classification
`default_nettype none
module tgee_front import tgee_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire logic   clear,
    input  wire logic   in_valid,
    output logic        in_stall,
    input  wire logic   cell_occupied,
    input  wire logic   q_full,
    output logic        push,
    output job_t        job
);

    logic [MAX_ROWS-1:0] west_reg, center_reg, east_reg;
    logic [MAX_ROWS-1:0] east_next;
    logic [COL_W-1:0]    col_reg;
    logic [HGT_W-1:0]    row_reg;
    logic [COL_W-1:0]    w_eff;
    logic [HGT_W-1:0]    h_eff;
    logic [HGT_W-1:0]    row_inc;
    logic [COL_W:0]      col_inc;
    logic [ROW_W-1:0]    y, ym1, yp1;
    logic                acc, col_end, frame_end, self_bit;

    always_comb
    begin
        w_eff = (cfg.width == '0) ? COL_W'(1) : cfg.width;
        if (cfg.height == '0)
            h_eff = HGT_W'(1);
        else if (cfg.height > HGT_W'(MAX_ROWS))
            h_eff = HGT_W'(MAX_ROWS);
        else
            h_eff = cfg.height;
    end

    assign in_stall  = q_full;
    assign acc       = in_valid && !q_full;
    assign row_inc   = row_reg + HGT_W'(1);
    assign col_inc   = (COL_W+1)'(col_reg) + (COL_W+1)'(1);
    assign col_end   = row_inc >= h_eff;
    assign frame_end = col_end && (col_inc >= (COL_W+1)'(w_eff));

    assign yp1 = row_reg[ROW_W-1:0];
    assign y   = yp1 - ROW_W'(1);
    assign ym1 = yp1 - ROW_W'(2);

    always_comb
    begin
        east_next = east_reg;
        east_next[row_reg[ROW_W-1:0]] = east_reg[row_reg[ROW_W-1:0]] | cell_occupied;
    end

    assign self_bit = center_reg[y];

    always_comb
    begin
        job.x         = col_reg - COL_W'(1);
        job.y         = y;
        job.has_w     = self_bit && !west_reg[y];
        job.has_e     = self_bit && !east_next[y];
        job.has_n     = self_bit && !center_reg[ym1];
        job.has_s     = self_bit && !center_reg[yp1];
        job.fv        = row_inc == h_eff;
        job.fh        = col_inc == (COL_W+1)'(w_eff);
        job.frame_end = frame_end;
    end

    // cell (c-1, r-1) becomes interior work once (c, r) is known
    assign push = acc && (col_reg >= COL_W'(2)) && (row_reg >= HGT_W'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            west_reg   <= '0;
            center_reg <= '0;
            east_reg   <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (clear || (acc && frame_end))
        begin
            west_reg   <= '0;
            center_reg <= '0;
            east_reg   <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (acc)
        begin
            if (col_end)
            begin
                west_reg   <= center_reg;
                center_reg <= east_next;
                east_reg   <= '0;
                col_reg    <= col_inc[COL_W-1:0];
                row_reg    <= '0;
            end
            else
            begin
                east_reg <= east_next;
                row_reg  <= row_inc;
            end
        end
    end

endmodule
`default_nettype wire

[design/tgee_queue.sv]
// short job queue between the front and back parts
`default_nettype none
module tgee_queue import tgee_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   clear,
    input  wire logic   push,
    input  wire job_t   wr_job,
    input  wire logic   pop,
    output job_t        head,
    output q_status_t   status
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QPTR_W:0]   cnt_reg;
    logic              do_push, do_pop;

    assign status.full  = cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign status.empty = cnt_reg == '0;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else if (clear)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= wr_reg + QPTR_W'(1);
            if (do_pop)
                rd_reg <= rd_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + (QPTR_W+1)'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - (QPTR_W+1)'(1);
        end
    end

endmodule
`default_nettype wire

[design/tgee_back.sv]
// back part: open run stores, id allocation, ordering and scaling of edges
`default_nettype none
module tgee_back import tgee_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfg_t                cfg,
    input  wire logic                clear,
    input  wire q_status_t           q_status,
    input  wire job_t                head,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [ID_W-1:0]          edge_index,
    output logic [COORD_W-1:0]       start_x,
    output logic [COORD_W-1:0]       start_y,
    output logic [COORD_W-1:0]       end_x,
    output logic [COORD_W-1:0]       end_y,
    output logic                     last_of_run,
    output logic                     id_overflow
);

    back_state_t         state_reg, state_next;

    logic [MAX_ROWS-1:0] nv_reg, sv_reg;
    logic [ID_W-1:0]     nid_reg [MAX_ROWS];
    logic [ID_W-1:0]     sid_reg [MAX_ROWS];
    logic [COL_W-1:0]    nst_reg [MAX_ROWS];
    logic [COL_W-1:0]    sst_reg [MAX_ROWS];
    logic                wv_reg, ev_reg;
    logic [ID_W-1:0]     wid_reg, eid_reg;
    logic [ROW_W-1:0]    wst_reg, est_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    fin_t                fin_reg [LANES];
    logic [LANES-1:0]    mask_reg, mask_next;
    logic                snap_reg;
    logic                out_valid_reg;

    logic [LANES-1:0]    has_l, flush_l, vin_l, vert_l, vout_l, emit_l;
    logic [ID_W-1:0]     idin_l [LANES];
    logic [ID_W-1:0]     idout_l [LANES];
    logic [COL_W-1:0]    stin_l [LANES];
    logic [COL_W-1:0]    stout_l [LANES];
    logic [COL_W-1:0]    pos_l [LANES];
    logic [COL_W-1:0]    fix_l [LANES];
    fin_t                fin_l [LANES];

    logic                take, load, emit_now;
    logic [LANE_W-1:0]   sel;
    fin_t                cur;
    logic [ORG_W-1:0]    org_fix, org_run;

    assign take = (state_reg == B_IDLE) && !q_status.empty;
    assign pop  = take;
    assign load = !out_valid_reg || !out_stall;

    // lanes in allocation order: west, east, north, south
    always_comb
    begin
        has_l   = {head.has_s, head.has_n, head.has_e, head.has_w};
        flush_l = {head.fh, head.fh, head.fv, head.fv};
        vert_l  = 4'b0011;
        vin_l   = {sv_reg[head.y], nv_reg[head.y], ev_reg, wv_reg};
        idin_l[0] = wid_reg;
        idin_l[1] = eid_reg;
        idin_l[2] = nid_reg[head.y];
        idin_l[3] = sid_reg[head.y];
        stin_l[0] = COL_W'(wst_reg);
        stin_l[1] = COL_W'(est_reg);
        stin_l[2] = nst_reg[head.y];
        stin_l[3] = sst_reg[head.y];
        pos_l[0]  = COL_W'(head.y);
        pos_l[1]  = COL_W'(head.y);
        pos_l[2]  = head.x;
        pos_l[3]  = head.x;
        fix_l[0]  = head.x;
        fix_l[1]  = head.x + COL_W'(1);
        fix_l[2]  = COL_W'(head.y);
        fix_l[3]  = COL_W'(head.y) + COL_W'(1);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        for (int i = 0; i < LANES; i++)
        begin
            vout_l[i]  = vin_l[i];
            idout_l[i] = idin_l[i];
            stout_l[i] = stin_l[i];
            emit_l[i]  = 1'b0;
            fin_l[i].id    = idin_l[i];
            fin_l[i].vert  = vert_l[i];
            fin_l[i].fixed = fix_l[i];
            fin_l[i].start = stin_l[i];
            fin_l[i].stop  = pos_l[i];
            if (has_l[i] && !vin_l[i])
            begin
                if (cnt_next < CNT_W'(MAX_EDGES))
                begin
                    idout_l[i] = cnt_next[ID_W-1:0];
                    cnt_next   = cnt_next + CNT_W'(1);
                    vout_l[i]  = 1'b1;
                    stout_l[i] = pos_l[i];
                end
                else
                    ovf_next = 1'b1;
            end
            if (!has_l[i] && vout_l[i])
            begin
                emit_l[i] = 1'b1;
                vout_l[i] = 1'b0;
            end
            if (flush_l[i] && vout_l[i])
            begin
                emit_l[i]      = 1'b1;
                vout_l[i]      = 1'b0;
                fin_l[i].id    = idout_l[i];
                fin_l[i].start = stout_l[i];
                fin_l[i].stop  = pos_l[i] + COL_W'(1);
            end
        end
    end

    // lowest pending id goes out first
    always_comb
    begin
        sel = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (mask_reg[i] && (!mask_reg[sel] || fin_reg[i].id < fin_reg[sel].id))
                sel = LANE_W'(i);
        end
    end

    assign cur      = fin_reg[sel];
    assign emit_now = (state_reg == B_EMIT) && load;
    assign org_fix  = cur.vert ? cfg.ocol : cfg.orow;
    assign org_run  = cur.vert ? cfg.orow : cfg.ocol;

    always_comb
    begin
        mask_next = mask_reg;
        mask_next[sel] = 1'b0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
                if (take && (emit_l != '0))
                    state_next = B_EMIT;
            B_EMIT:
                if (load && (mask_next == '0))
                    state_next = B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else if (clear)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg        <= '0;
            sv_reg        <= '0;
            wv_reg        <= 1'b0;
            ev_reg        <= 1'b0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            nv_reg        <= '0;
            sv_reg        <= '0;
            wv_reg        <= 1'b0;
            ev_reg        <= 1'b0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                mask_reg <= emit_l;
                if (head.frame_end)
                begin
                    nv_reg  <= '0;
                    sv_reg  <= '0;
                    wv_reg  <= 1'b0;
                    ev_reg  <= 1'b0;
                    cnt_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                else
                begin
                    wv_reg          <= vout_l[0];
                    ev_reg          <= vout_l[1];
                    nv_reg[head.y]  <= vout_l[2];
                    sv_reg[head.y]  <= vout_l[3];
                    cnt_reg         <= cnt_next;
                    ovf_reg         <= ovf_next;
                end
            end
            else if (emit_now)
                mask_reg <= mask_next;
            if (load)
                out_valid_reg <= state_reg == B_EMIT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            wid_reg          <= idout_l[0];
            eid_reg          <= idout_l[1];
            nid_reg[head.y]  <= idout_l[2];
            sid_reg[head.y]  <= idout_l[3];
            wst_reg          <= stout_l[0][ROW_W-1:0];
            est_reg          <= stout_l[1][ROW_W-1:0];
            nst_reg[head.y]  <= stout_l[2];
            sst_reg[head.y]  <= stout_l[3];
            for (int i = 0; i < LANES; i++)
                fin_reg[i] <= fin_l[i];
            snap_reg <= ovf_next;
        end
        if (emit_now)
        begin
            edge_index  <= cur.id;
            last_of_run <= mask_next == '0;
            id_overflow <= snap_reg;
            if (cur.vert)
            begin
                start_x <= coord(org_fix, cur.fixed, cfg.bsize);
                end_x   <= coord(org_fix, cur.fixed, cfg.bsize);
                start_y <= coord(org_run, cur.start, cfg.bsize);
                end_y   <= coord(org_run, cur.stop, cfg.bsize);
            end
            else
            begin
                start_y <= coord(org_fix, cur.fixed, cfg.bsize);
                end_y   <= coord(org_fix, cur.fixed, cfg.bsize);
                start_x <= coord(org_run, cur.start, cfg.bsize);
                end_x   <= coord(org_run, cur.stop, cfg.bsize);
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

[design/tile_grid_edge_extract_core.sv]
// Tile grid edge extractor: takes one occupancy bit per transaction, column by
// column with the row inner, and returns the finished boundary edges of the
// window (id, endpoints in world units). The front part accepts one cell per
// cycle into a four-entry job queue; the back part first updates the open run
// stores for each interior cell and then emits its finished edges (zero to four
// per cell), holding them while the receiver stalls, and takes no new cell
// until the cell's last edge has gone out. Input stalls while the queue is full.
// A write to any register aborts the frame and returns all scan state to reset.
`default_nettype none
module tile_grid_edge_extract_core import tgee_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                cell_occupied,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [ID_W-1:0]          edge_index,
    output logic [COORD_W-1:0]       start_x,
    output logic [COORD_W-1:0]       start_y,
    output logic [COORD_W-1:0]       end_x,
    output logic [COORD_W-1:0]       end_y,
    output logic                     last_of_run,
    output logic                     id_overflow
);

    cfg_t             cfg_reg;
    logic [IDX_W-1:0] idx;
    logic             wr, clear, push, pop;
    job_t             job, head;
    q_status_t        q_status;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr     = psel && penable && pwrite && pready;
    assign clear  = wr && (idx < IDX_W'(NUM_REGS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= COL_W'(20);
            cfg_reg.height <= HGT_W'(20);
            cfg_reg.bsize  <= BS_W'(32);
            cfg_reg.ocol   <= '0;
            cfg_reg.orow   <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_WIDTH:  cfg_reg.width  <= pwdata[COL_W-1:0];
                REG_HEIGHT: cfg_reg.height <= pwdata[HGT_W-1:0];
                REG_BSIZE:  cfg_reg.bsize  <= pwdata[BS_W-1:0];
                REG_OCOL:   cfg_reg.ocol   <= pwdata[ORG_W-1:0];
                REG_OROW:   cfg_reg.orow   <= pwdata[ORG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_WIDTH:  prdata = 32'(cfg_reg.width);
            REG_HEIGHT: prdata = 32'(cfg_reg.height);
            REG_BSIZE:  prdata = 32'(cfg_reg.bsize);
            REG_OCOL:   prdata = 32'(cfg_reg.ocol);
            REG_OROW:   prdata = 32'(cfg_reg.orow);
            default:    prdata = '0;
        endcase
    end

    tgee_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .clear         (clear),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cell_occupied (cell_occupied),
        .q_full        (q_status.full),
        .push          (push),
        .job           (job)
    );

    tgee_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (clear),
        .push   (push),
        .wr_job (job),
        .pop    (pop),
        .head   (head),
        .status (q_status)
    );

    tgee_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .clear       (clear),
        .q_status    (q_status),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .edge_index  (edge_index),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .last_of_run (last_of_run),
        .id_overflow (id_overflow)
    );

endmodule
`default_nettype wire

[design/tgee_checker.sv]
// port level checks of the edge extract core and their bind
`default_nettype none
`include "tile_grid_edge_extract_core_macros.svh"
module tgee_core_props import tgee_pkg::*; (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            out_valid,
    input wire logic            out_stall,
    input wire logic [ID_W-1:0] edge_index,
    input wire logic            last_of_run,
    input wire logic            id_overflow
);

    // a stalled result keeps its place
    `TGEE_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(edge_index))

    // the rest of a cell's edges follow without a gap
    `TGEE_ASSERT_NEXT(a_burst, out_valid && !out_stall && !last_of_run, out_valid)

    // the overflow flag is one value across a cell's edges
    `TGEE_ASSERT_NEXT(a_ovf_run, out_valid && !out_stall && !last_of_run, $stable(id_overflow))

    // the flag only rises along with a valid result
    `TGEE_ASSERT_NOW(a_ovf_rise, $rose(id_overflow), out_valid)

endmodule

bind tile_grid_edge_extract_core tgee_core_props u_tgee_core_props (.*);
`default_nettype wire

[test/tgee_checker.sv]
`timescale 1ns / 100ps
// checker for the edge extract core: edge predictor and result comparison
module tgee_checker import tgee_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic                pready,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [31:0]         pwdata,
    input  wire logic                in_valid,
    input  wire logic                in_stall,
    input  wire logic                cell_occupied,
    input  wire logic                out_valid,
    input  wire logic                out_stall,
    input  wire logic [ID_W-1:0]     edge_index,
    input  wire logic [COORD_W-1:0]  start_x,
    input  wire logic [COORD_W-1:0]  start_y,
    input  wire logic [COORD_W-1:0]  end_x,
    input  wire logic [COORD_W-1:0]  end_y,
    input  wire logic                last_of_run,
    input  wire logic                id_overflow,
    output int                       errors,
    output int                       pending
);

    typedef struct {
        logic [ID_W-1:0]    id;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic               last;
        logic               ovf;
    } edge_rec_t;

    typedef struct {
        logic             valid;
        logic [ID_W-1:0]  id;
        int               start;
    } open_run_t;

    // run slots: 0..31 north per row, 32..63 south per row, 64 west, 65 east
    localparam int RUN_WEST = 2 * MAX_ROWS;
    localparam int RUN_EAST = 2 * MAX_ROWS + 1;

    logic [COL_W-1:0] cfg_width;
    logic [HGT_W-1:0] cfg_height;
    logic [BS_W-1:0]  cfg_bsize;
    logic [ORG_W-1:0] cfg_ocol;
    logic [ORG_W-1:0] cfg_orow;

    logic [MAX_ROWS-1:0] west_bits, center_bits, east_bits;
    open_run_t           runs[0:2*MAX_ROWS+1];
    int                  next_id;
    int                  col_cnt, row_cnt;
    logic                ids_exhausted;

    edge_rec_t step_edges[0:7];
    int        n_step;
    edge_rec_t edges_due[$];

    function automatic logic [COORD_W-1:0] to_world(int org, int idx);
        return COORD_W'((org + idx) * int'(cfg_bsize));
    endfunction

    task automatic clear_scan();
        west_bits = '0;
        center_bits = '0;
        east_bits = '0;
        for (int k = 0; k < 2 * MAX_ROWS + 2; k++)
            runs[k] = '{valid: 1'b0, id: '0, start: 0};
        next_id = 0;
        col_cnt = 0;
        row_cnt = 0;
        ids_exhausted = 1'b0;
    endtask

    task automatic close_run(int k, bit vert, int fixed, int stop);
        edge_rec_t e;
        e.id = runs[k].id;
        if (vert) begin
            e.sx = to_world(cfg_ocol, fixed);
            e.ex = e.sx;
            e.sy = to_world(cfg_orow, runs[k].start);
            e.ey = to_world(cfg_orow, stop);
        end
        else begin
            e.sy = to_world(cfg_orow, fixed);
            e.ey = e.sy;
            e.sx = to_world(cfg_ocol, runs[k].start);
            e.ex = to_world(cfg_ocol, stop);
        end
        e.last = 1'b0;
        e.ovf = 1'b0;
        if (n_step < 8) begin
            step_edges[n_step] = e;
            n_step++;
        end
        runs[k].valid = 1'b0;
    endtask

    // pos runs along the edge: row for vertical runs, column for horizontal ones
    task automatic run_update(int k, bit has, bit vert, int fixed, int pos, bit flush);
        if (has) begin
            if (!runs[k].valid) begin
                if (next_id < MAX_EDGES) begin
                    runs[k].valid = 1'b1;
                    runs[k].id = ID_W'(next_id);
                    runs[k].start = pos;
                    next_id++;
                end
                else
                    ids_exhausted = 1'b1;
            end
        end
        else if (runs[k].valid)
            close_run(k, vert, fixed, pos);
        if (flush && runs[k].valid)
            close_run(k, vert, fixed, pos + 1);
    endtask

    task automatic take_cell(logic occ);
        int        w, h, c, r, x, y;
        bit        self;
        edge_rec_t t;
        int        j;
        w = (cfg_width == 0) ? 1 : int'(cfg_width);
        h = (cfg_height == 0) ? 1 : int'(cfg_height);
        if (h > MAX_ROWS)
            h = MAX_ROWS;
        c = col_cnt;
        r = row_cnt;
        n_step = 0;
        if (r < MAX_ROWS && occ)
            east_bits[r] = 1'b1;
        if (c >= 2 && r >= 2 && r - 1 < MAX_ROWS) begin
            x = c - 1;
            y = r - 1;
            self = center_bits[y];
            run_update(RUN_WEST, self && !west_bits[y], 1'b1, x, y, r == h - 1);
            run_update(RUN_EAST, self && !east_bits[y], 1'b1, x + 1, y, r == h - 1);
            run_update(y, self && !center_bits[y-1], 1'b0, y, x, c == w - 1);
            run_update(MAX_ROWS + y, self && !center_bits[y+1], 1'b0, y + 1, x,
                       c == w - 1);
        end
        for (int i = 1; i < n_step; i++) begin
            t = step_edges[i];
            j = i - 1;
            while (j >= 0 && step_edges[j].id > t.id) begin
                step_edges[j+1] = step_edges[j];
                j--;
            end
            step_edges[j+1] = t;
        end
        for (int i = 0; i < n_step; i++) begin
            t = step_edges[i];
            t.last = (i == n_step - 1);
            t.ovf = ids_exhausted;
            edges_due.insert(edges_due.size(), t);
        end
        r++;
        if (r >= h) begin
            r = 0;
            west_bits = center_bits;
            center_bits = east_bits;
            east_bits = '0;
            c++;
            if (c >= w) begin
                clear_scan();
                c = 0;
            end
        end
        col_cnt = c & 'h7FF;
        row_cnt = r & 'h3F;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        edge_rec_t e;
        if (!rst_n) begin
            cfg_width = 20;
            cfg_height = 20;
            cfg_bsize = 32;
            cfg_ocol = 0;
            cfg_orow = 0;
            clear_scan();
            edges_due.delete();
            errors = 0;
            pending = 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_WIDTH:  begin cfg_width = pwdata[COL_W-1:0];  clear_scan(); end
                    REG_HEIGHT: begin cfg_height = pwdata[HGT_W-1:0]; clear_scan(); end
                    REG_BSIZE:  begin cfg_bsize = pwdata[BS_W-1:0];   clear_scan(); end
                    REG_OCOL:   begin cfg_ocol = pwdata[ORG_W-1:0];   clear_scan(); end
                    REG_OROW:   begin cfg_orow = pwdata[ORG_W-1:0];   clear_scan(); end
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                take_cell(cell_occupied);
            if (out_valid && !out_stall) begin
                if (edges_due.size() == 0) begin
                    $display("%0t: unexpected edge transaction, actual id %0d",
                             $time, edge_index);
                    errors++;
                end
                else begin
                    e = edges_due.pop_front();
                    check_field("edge_index", e.id, edge_index);
                    check_field("start_x", e.sx, start_x);
                    check_field("start_y", e.sy, start_y);
                    check_field("end_x", e.ex, end_x);
                    check_field("end_y", e.ey, end_y);
                    check_field("last_of_run", e.last, last_of_run);
                    check_field("id_overflow", e.ovf, id_overflow);
                end
            end
            pending = edges_due.size();
        end
    end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// testbench top for the edge extract core: cell stimulus, config writes, verdict
module tb import tgee_pkg::*;;

    localparam int SETTLE = 64;

    logic               clk;
    logic               rst_n;
    logic               psel, penable, pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid, in_stall, cell_occupied;
    logic               out_valid, out_stall;
    logic [ID_W-1:0]    edge_index;
    logic [COORD_W-1:0] start_x, start_y, end_x, end_y;
    logic               last_of_run, id_overflow;
    int                 errors, pending;

    bit tx_quiet, rx_quiet, squeeze_req;

    tile_grid_edge_extract_core i_dut (.*);

    tgee_checker i_checker (.*);

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver: random stall per transaction, plus one long hold on request
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
            end
            n = rx_quiet ? 0 : $urandom_range(0, 10);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(negedge clk); while (!out_valid && !squeeze_req);
            @(posedge clk);
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, int val, int bits);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= (32'($urandom) << bits) | 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_cell(logic occ);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cell_occupied <= occ;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
    endtask

    task automatic send_cells(int n, int density);
        for (int i = 0; i < n; i++)
            send_cell($urandom_range(0, 99) < density);
    endtask

    // wait for all edges, then let the back part run dry before a write
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_window(int w, int h, int bs, int oc, int orow);
        write_reg(REG_WIDTH, w, COL_W);
        write_reg(REG_HEIGHT, h, HGT_W);
        write_reg(REG_BSIZE, bs, BS_W);
        write_reg(REG_OCOL, oc, ORG_W);
        write_reg(REG_OROW, orow, ORG_W);
    endtask

    task automatic send_pattern(logic [8:0] bits);
        for (int i = 0; i < 9; i++)
            send_cell(bits[i]);
    endtask

    initial
    begin
        int w, h;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        cell_occupied = 1'b0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        squeeze_req = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 window: one interior cell with four, three or no boundary edges, all flushed
        set_window(3, 3, 1, 0, 0);
        send_pattern(9'b000010000);
        send_pattern(9'b111111111);
        send_pattern(9'b000001000);
        send_pattern(9'b000011000);
        drain();
        // largest origin and block size in a 3x3 window
        set_window(3, 3, 255, 1023, 1023);
        send_pattern(9'b000010000);
        drain();
        // degenerate windows emit nothing
        set_window(0, 0, 1, 0, 0);
        send_cells(4, 50);
        drain();
        write_reg(IDX_W'(NUM_REGS), 'h1F, 5);
        set_window(2047, 63, 7, 0, 5);
        send_cells(80, 50);
        drain();

        // reset sizes, start of a frame
        set_window(20, 20, 32, 0, 0);
        send_cells(60, 50);
        drain();

        // tallest window, one frame back to back under a long receiver hold
        set_window(5, 32, 255, 1023, 0);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        squeeze_req = 1'b1;
        send_cells(160, 70);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        drain();

        for (int p = 0; p < 3; p++)
        begin
            w = $urandom_range(3, 8);
            h = $urandom_range(3, 8);
            set_window(w, h, $urandom_range(1, 255), $urandom_range(0, 1023),
                       $urandom_range(0, 1023));
            send_cells(w * h * $urandom_range(1, 2) + $urandom_range(0, 5),
                       (p % 3 == 0) ? 15 : (p % 3 == 1) ? 50 : 85);
            drain();
        end

        // wide window of 1024 columns, shortest height with interior cells
        set_window(1024, 3, 255, 0, 1023);
        send_cells(40, 50);
        drain();

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/tgee_pkg.sv
design/tgee_front.sv
design/tgee_queue.sv
design/tgee_back.sv
design/tile_grid_edge_extract_core.sv
design/tgee_checker.sv
test/tgee_checker.sv
test/tb.sv
